FILE: hw/rtl/bir_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear resampler package
// Shared widths, register indexes, command codes, sequencer states and the
// control word of the multiply-accumulate unit.
// ----------------------------------------------------------------------------
package bir_pkg;

  // Fixed field widths
  localparam int PIX_W         = 8;
  localparam int WR_COORD_W    = 6;
  localparam int OUT_COORD_W   = 10;
  localparam int IN_DIM_CFG_W  = 7;
  localparam int OUT_DIM_CFG_W = 11;
  localparam int CFG_DATA_W    = 11;
  localparam int CFG_IDX_W     = 2;

  // Quotient bits retired per divider cycle
  localparam int DIV_STEP_BITS = 4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 2'd3;

  // Register reset values
  localparam logic [IN_DIM_CFG_W-1:0]  IN_WIDTH_RST   = 7'd28;
  localparam logic [IN_DIM_CFG_W-1:0]  IN_HEIGHT_RST  = 7'd28;
  localparam logic [OUT_DIM_CFG_W-1:0] OUT_WIDTH_RST  = 11'd224;
  localparam logic [OUT_DIM_CFG_W-1:0] OUT_HEIGHT_RST = 11'd224;

  // Command codes
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_MAP_X,
    S_START_X,
    S_DIV_X,
    S_MAP_Y,
    S_START_Y,
    S_DIV_Y,
    S_RD00,
    S_RD01,
    S_RD10,
    S_RD11,
    S_MUL11,
    S_WAIT_H,
    S_BLEND_Y0,
    S_BLEND_Y1,
    S_WAIT_Y,
    S_DONE
  } seq_state_e;

  // Multiply-accumulate control word
  typedef struct packed {
    logic valid;
    logic clear;
    logic round;
  } mac_ctrl_t;

endpackage

FILE: hw/rtl/bir_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial restoring divider
// Divides num_i * 2^FRAC_BITS by den_i, retiring DIV_STEP_BITS quotient bits
// per cycle. The integer quotient sits above the fraction bits of quot_o.
// ----------------------------------------------------------------------------
module bir_divider #(
  parameter int NUM_W     = 18,
  parameter int DEN_W     = 12,
  parameter int FRAC_BITS = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [NUM_W-1:0]           num_i,
  input  logic [DEN_W-1:0]           den_i,
  output logic                       done_o,
  output logic [NUM_W+FRAC_BITS-1:0] quot_o
);
  import bir_pkg::*;

  localparam int TW    = NUM_W + FRAC_BITS;
  localparam int TWP   = ((TW + DIV_STEP_BITS - 1) / DIV_STEP_BITS) * DIV_STEP_BITS;
  localparam int STEPS = TWP / DIV_STEP_BITS;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [TWP-1:0]   sh_q, sh_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q;

  // Retire several quotient bits: shift in a dividend bit, trial subtract
  always_comb begin : p_step
    logic [DEN_W:0] trial;
    logic           qbit;
    rem_d = rem_q;
    sh_d  = sh_q;
    for (int k = 0; k < DIV_STEP_BITS; k++) begin
      trial = {rem_d, sh_d[TWP-1]};
      qbit  = (trial >= {1'b0, den_q});
      if (qbit) begin
        rem_d = DEN_W'(trial - {1'b0, den_q});
      end else begin
        rem_d = trial[DEN_W-1:0];
      end
      sh_d = {sh_d[TWP-2:0], qbit};
    end
  end

  // Step counter and completion pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Load operands, then advance the shift pair
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= TWP'({num_i, {FRAC_BITS{1'b0}}});
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      sh_q  <= sh_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = sh_q[TW-1:0];

endmodule

FILE: hw/rtl/bir_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source pixel store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bir_store #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [ADDR_W-1:0]         waddr_i,
  input  logic [bir_pkg::PIX_W-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [ADDR_W-1:0]         raddr_i,
  output logic [bir_pkg::PIX_W-1:0] rdata_o
);
  import bir_pkg::*;

  logic [PIX_W-1:0] pix_mem [DEPTH];
  logic [PIX_W-1:0] rdata_q;

  // Store a written pixel
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      pix_mem[waddr_i] <= wdata_i;
    end
  end

  // Register the read word
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= pix_mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/bir_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared multiply-accumulate unit
// Registered product, accumulated in the cycle after it. A clear starts a new
// sum at zero, or at one half LSB of the output when round is set.
// ----------------------------------------------------------------------------
module bir_mac #(
  parameter int FRAC_BITS = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  bir_pkg::mac_ctrl_t                    ctrl_i,
  input  logic [bir_pkg::PIX_W+FRAC_BITS-1:0]   a_i,
  input  logic [FRAC_BITS:0]                    b_i,
  output logic [bir_pkg::PIX_W+2*FRAC_BITS:0]   acc_o
);
  import bir_pkg::*;

  localparam int A_W   = PIX_W + FRAC_BITS;
  localparam int ACC_W = A_W + FRAC_BITS + 1;
  localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (2 * FRAC_BITS - 1);

  mac_ctrl_t        ctrl_q;
  logic [ACC_W-1:0] prod_q;
  logic [ACC_W-1:0] acc_q;
  logic [ACC_W-1:0] base;

  // Hold the control word alongside the product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_i;
    end
  end

  // Multiply stage
  always_ff @(posedge clk_i) begin
    if (ctrl_i.valid) begin
      prod_q <= a_i * b_i;
    end
  end

  // Pick the starting value of the sum
  always_comb begin
    if (!ctrl_q.clear) begin
      base = acc_q;
    end else if (ctrl_q.round) begin
      base = HALF;
    end else begin
      base = '0;
    end
  end

  // Accumulate stage
  always_ff @(posedge clk_i) begin
    if (ctrl_q.valid) begin
      acc_q <= base + prod_q;
    end
  end

  assign acc_o = acc_q;

endmodule

FILE: hw/rtl/bilinear_image_resampler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear image resampler
// Stores 8-bit source pixels and samples destination pixels with half-pixel
// centers, blending the four neighbors in fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a word is taken at a rising edge with start_i high and
//   busy_o low. A write command stores write_value_i at (write_row_i,
//   write_col_i) in that same edge and leaves busy_o low, so writes go at
//   one per cycle. A sample command raises busy_o until its result is out.
//   Result channel: res_valid_o marks pixel_value_o, res_col_o, res_row_o for
//   exactly one cycle; the receiver takes it and cannot stall it.
//   Sequence: a sample maps its column and then its row through the single
//   shared divider, run once per axis, which takes most of the time; the rest
//   is four store reads and six passes through the shared multiplier. The
//   next command is taken in the cycle after the result is shown.
//   Configuration: cfg_we_i writes register cfg_idx_i; the user must write
//   only while idle, since the block itself does no check of it.
//   Reset: registers take their default dimensions; the pixel store holds
//   nothing defined until written, and no clearing pass runs.
// ----------------------------------------------------------------------------
module bilinear_image_resampler_unit #(
  parameter int MAX_IN_DIM  = 64,
  parameter int MAX_OUT_DIM = 1024,
  parameter int FRAC_BITS   = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bir_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [bir_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic                             command_i,
  input  logic [bir_pkg::WR_COORD_W-1:0]   write_col_i,
  input  logic [bir_pkg::WR_COORD_W-1:0]   write_row_i,
  input  logic [bir_pkg::PIX_W-1:0]        write_value_i,
  input  logic [bir_pkg::OUT_COORD_W-1:0]  out_col_i,
  input  logic [bir_pkg::OUT_COORD_W-1:0]  out_row_i,
  output logic                             res_valid_o,
  output logic [bir_pkg::PIX_W-1:0]        pixel_value_o,
  output logic [bir_pkg::OUT_COORD_W-1:0]  res_col_o,
  output logic [bir_pkg::OUT_COORD_W-1:0]  res_row_o
);
  import bir_pkg::*;

  localparam int IN_W   = $clog2(MAX_IN_DIM + 1);
  localparam int OUT_W  = $clog2(MAX_OUT_DIM + 1);
  localparam int IDX_W  = $clog2(MAX_IN_DIM);
  localparam int DEPTH  = MAX_IN_DIM * MAX_IN_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int NUM_W  = OUT_COORD_W + 1 + IN_W;
  localparam int DEN_W  = OUT_W + 1;
  localparam int QUOT_W = NUM_W + FRAC_BITS;
  localparam int A_W    = PIX_W + FRAC_BITS;
  localparam int WT_W   = FRAC_BITS + 1;
  localparam int ACC_W  = A_W + WT_W;
  localparam logic [WT_W-1:0] ONE_WT = WT_W'(1) << FRAC_BITS;

  // Configuration registers
  logic [IN_DIM_CFG_W-1:0]  in_width_q, in_height_q;
  logic [OUT_DIM_CFG_W-1:0] out_width_q, out_height_q;
  logic [IN_W-1:0]          iw_eff, ih_eff;
  logic [OUT_W-1:0]         ow_eff, oh_eff;

  // Sequencer and item state
  seq_state_e               state_q, state_d;
  logic                     accept;
  logic [OUT_COORD_W-1:0]   ocol_q, orow_q;
  logic [NUM_W-1:0]         pos_q;
  logic [IDX_W-1:0]         x0_q, x1_q, y0_q, y1_q;
  logic [FRAC_BITS-1:0]     fx_q, fy_q;
  logic [A_W-1:0]           h0_q, h1_q;

  // Axis mapping
  logic                     axis_y;
  logic [OUT_COORD_W-1:0]   sel_coord;
  logic [IN_W-1:0]          sel_in, in_m1;
  logic [OUT_W-1:0]         sel_out;
  logic [NUM_W-1:0]         out_ext, div_num;
  logic [DEN_W-1:0]         div_den;
  logic                     div_start, div_done;
  logic [QUOT_W-1:0]        div_quot;
  logic [NUM_W-1:0]         q_int;
  logic [FRAC_BITS-1:0]     q_frac, map_frac;
  logic                     at_edge, past_edge;
  logic [IDX_W-1:0]         map_i0, map_i1;

  // Store ports
  logic                     mem_we, mem_re;
  logic [ADDR_W-1:0]        mem_waddr, mem_raddr;
  logic [PIX_W-1:0]         mem_rdata;
  logic [IDX_W-1:0]         rd_row, rd_col;

  // Blend unit ports
  mac_ctrl_t                mac_ctrl;
  logic [A_W-1:0]           mac_a;
  logic [WT_W-1:0]          mac_b;
  logic [ACC_W-1:0]         mac_acc;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_width_q   <= IN_WIDTH_RST;
      in_height_q  <= IN_HEIGHT_RST;
      out_width_q  <= OUT_WIDTH_RST;
      out_height_q <= OUT_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_IN_WIDTH:   in_width_q   <= cfg_data_i[IN_DIM_CFG_W-1:0];
        REG_IN_HEIGHT:  in_height_q  <= cfg_data_i[IN_DIM_CFG_W-1:0];
        REG_OUT_WIDTH:  out_width_q  <= cfg_data_i[OUT_DIM_CFG_W-1:0];
        REG_OUT_HEIGHT: out_height_q <= cfg_data_i[OUT_DIM_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp dimensions: zero acts as one, oversize acts as the maximum
  always_comb begin
    if (in_width_q == '0) begin
      iw_eff = IN_W'(1);
    end else if (in_width_q > MAX_IN_DIM) begin
      iw_eff = IN_W'(MAX_IN_DIM);
    end else begin
      iw_eff = IN_W'(in_width_q);
    end
    if (in_height_q == '0) begin
      ih_eff = IN_W'(1);
    end else if (in_height_q > MAX_IN_DIM) begin
      ih_eff = IN_W'(MAX_IN_DIM);
    end else begin
      ih_eff = IN_W'(in_height_q);
    end
    if (out_width_q == '0) begin
      ow_eff = OUT_W'(1);
    end else if (out_width_q > MAX_OUT_DIM) begin
      ow_eff = OUT_W'(MAX_OUT_DIM);
    end else begin
      ow_eff = OUT_W'(out_width_q);
    end
    if (out_height_q == '0) begin
      oh_eff = OUT_W'(1);
    end else if (out_height_q > MAX_OUT_DIM) begin
      oh_eff = OUT_W'(MAX_OUT_DIM);
    end else begin
      oh_eff = OUT_W'(out_height_q);
    end
  end

  // Accept a command word; drop writes outside the store
  assign accept    = start_i && (state_q == S_IDLE);
  assign mem_we    = accept && (command_i == CMD_WRITE) &&
                     (write_col_i < MAX_IN_DIM) && (write_row_i < MAX_IN_DIM);
  assign mem_waddr = ADDR_W'(write_row_i) * ADDR_W'(MAX_IN_DIM) + ADDR_W'(write_col_i);

  // Select the axis being mapped
  assign axis_y    = (state_q == S_MAP_Y) || (state_q == S_START_Y) ||
                     (state_q == S_DIV_Y);
  assign sel_coord = axis_y ? orow_q : ocol_q;
  assign sel_in    = axis_y ? ih_eff : iw_eff;
  assign sel_out   = axis_y ? oh_eff : ow_eff;
  assign in_m1     = sel_in - 1'b1;

  // Numerator clamped at zero, divisor twice the output size
  assign out_ext = NUM_W'(sel_out);
  assign div_num = (pos_q > out_ext) ? (pos_q - out_ext) : '0;
  assign div_den = {sel_out, 1'b0};

  bir_divider #(
    .NUM_W     (NUM_W),
    .DEN_W     (DEN_W),
    .FRAC_BITS (FRAC_BITS)
  ) u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Split the quotient and clamp neighbors at the far edge
  assign q_int     = div_quot[QUOT_W-1:FRAC_BITS];
  assign q_frac    = div_quot[FRAC_BITS-1:0];
  assign at_edge   = q_int >= NUM_W'(in_m1);
  assign past_edge = q_int > NUM_W'(in_m1);
  assign map_i0    = at_edge ? IDX_W'(in_m1) : IDX_W'(q_int);
  assign map_i1    = at_edge ? IDX_W'(in_m1) : IDX_W'(q_int) + 1'b1;
  assign map_frac  = past_edge ? '0 : q_frac;

  // Item registers: coordinates, mapped positions, partial blends
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ocol_q <= out_col_i;
      orow_q <= out_row_i;
    end
    if ((state_q == S_MAP_X) || (state_q == S_MAP_Y)) begin
      pos_q <= NUM_W'({sel_coord, 1'b1}) * NUM_W'(sel_in);
    end
    if ((state_q == S_DIV_X) && div_done) begin
      x0_q <= map_i0;
      x1_q <= map_i1;
      fx_q <= map_frac;
    end
    if ((state_q == S_DIV_Y) && div_done) begin
      y0_q <= map_i0;
      y1_q <= map_i1;
      fy_q <= map_frac;
    end
    if (state_q == S_MUL11) begin
      h0_q <= mac_acc[A_W-1:0];
    end
    if (state_q == S_BLEND_Y0) begin
      h1_q <= mac_acc[A_W-1:0];
    end
  end

  assign mem_raddr = ADDR_W'(rd_row) * ADDR_W'(MAX_IN_DIM) + ADDR_W'(rd_col);

  bir_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (write_value_i),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  bir_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .acc_o  (mac_acc)
  );

  // Advance the sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && (command_i == CMD_SAMPLE)) begin
          state_d = S_MAP_X;
        end
      end
      S_MAP_X:    state_d = S_START_X;
      S_START_X:  state_d = S_DIV_X;
      S_DIV_X: begin
        if (div_done) begin
          state_d = S_MAP_Y;
        end
      end
      S_MAP_Y:    state_d = S_START_Y;
      S_START_Y:  state_d = S_DIV_Y;
      S_DIV_Y: begin
        if (div_done) begin
          state_d = S_RD00;
        end
      end
      S_RD00:     state_d = S_RD01;
      S_RD01:     state_d = S_RD10;
      S_RD10:     state_d = S_RD11;
      S_RD11:     state_d = S_MUL11;
      S_MUL11:    state_d = S_WAIT_H;
      S_WAIT_H:   state_d = S_BLEND_Y0;
      S_BLEND_Y0: state_d = S_BLEND_Y1;
      S_BLEND_Y1: state_d = S_WAIT_Y;
      S_WAIT_Y:   state_d = S_DONE;
      S_DONE:     state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // State outputs: divider start, store reads, blend operations
  always_comb begin
    busy_o      = (state_q != S_IDLE);
    res_valid_o = 1'b0;
    div_start   = 1'b0;
    mem_re      = 1'b0;
    rd_row      = y0_q;
    rd_col      = x0_q;
    mac_ctrl    = '0;
    mac_a       = A_W'(mem_rdata);
    mac_b       = ONE_WT - WT_W'(fx_q);
    case (state_q)
      S_START_X, S_START_Y: begin
        div_start = 1'b1;
      end
      S_RD00: begin
        mem_re = 1'b1;
      end
      S_RD01: begin
        mem_re         = 1'b1;
        rd_col         = x1_q;
        mac_ctrl.valid = 1'b1;
        mac_ctrl.clear = 1'b1;
      end
      S_RD10: begin
        mem_re         = 1'b1;
        rd_row         = y1_q;
        mac_ctrl.valid = 1'b1;
        mac_b          = WT_W'(fx_q);
      end
      S_RD11: begin
        mem_re         = 1'b1;
        rd_row         = y1_q;
        rd_col         = x1_q;
        mac_ctrl.valid = 1'b1;
        mac_ctrl.clear = 1'b1;
      end
      S_MUL11: begin
        mac_ctrl.valid = 1'b1;
        mac_b          = WT_W'(fx_q);
      end
      S_BLEND_Y0: begin
        mac_ctrl.valid = 1'b1;
        mac_ctrl.clear = 1'b1;
        mac_ctrl.round = 1'b1;
        mac_a          = h0_q;
        mac_b          = ONE_WT - WT_W'(fy_q);
      end
      S_BLEND_Y1: begin
        mac_ctrl.valid = 1'b1;
        mac_a          = h1_q;
        mac_b          = WT_W'(fy_q);
      end
      S_DONE: begin
        res_valid_o = 1'b1;
      end
      default: ;
    endcase
  end

  assign pixel_value_o = mac_acc[2*FRAC_BITS +: PIX_W];
  assign res_col_o     = ocol_q;
  assign res_row_o     = orow_q;

endmodule

FILE: hw/rtl/bir_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Resampler port checker
// Watches the command and result handshakes of the top level over time.
// ----------------------------------------------------------------------------
module bir_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic command_i,
  input logic busy_o,
  input logic res_valid_o
);
  import bir_pkg::*;

  // A sample word raises busy on the next cycle
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (command_i == CMD_SAMPLE)) |=> busy_o)
    else $error("sample word did not raise busy");

  // A write word yields no result and leaves the block free
  a_write_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (command_i == CMD_WRITE)) |=> (!busy_o && !res_valid_o))
    else $error("write word made the block busy or gave a result");

  // A result only appears while a sample is in flight
  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> busy_o)
    else $error("result strobe without a sample in flight");

  // One result per sample, then the block is free again
  a_result_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> (!res_valid_o && !busy_o))
    else $error("result strobe repeated or block stayed busy");

endmodule

bind bilinear_image_resampler_unit bir_checker u_bir_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .command_i   (command_i),
  .busy_o      (busy_o),
  .res_valid_o (res_valid_o)
);
